FILE: src/sda_pkg.sv
package sda_pkg;

    // Stream payload widths. The slave side carries sample_value alone in tdata.
    // The master side carries rank_origin then ranked_value, padded to whole bytes.
    localparam int SAMPLE_W   = 32;
    localparam int ORIGIN_W   = 4;
    localparam int S_TDATA_W  = 32;
    localparam int M_PAYLOAD_W = ORIGIN_W + SAMPLE_W;
    localparam int M_TDATA_W  = ((M_PAYLOAD_W + 7) / 8) * 8;

    // Sequencer states of the load, sort and emit phases.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT_PRIME,
        ST_SORT_LOADC,
        ST_SORT_RUN,
        ST_SORT_TAIL,
        ST_OUT_PRIME,
        ST_OUT_SHOW
    } state_t;

endpackage

FILE: src/stable_descending_argsort.sv
// Channel   | Signals                              | Content
// ----------+--------------------------------------+-----------------------------------------
// s (input) | s_tvalid s_tready s_tdata s_tlast    | one value per request; tlast closes set
// m (output)| m_tvalid m_tready m_tdata m_tlast    | one ranked entry per request, largest
//           | m_tuser                              | first; tlast on the last, tuser overflow
//
// A set of n stored values is loaded, then sorted by a bubble sort on one shared
// signed comparator that walks the entry memory one entry per cycle. When n is 1 the sort
// is skipped for a single output priming state. Then the n results leave at one per cycle
// while m_tready is high.
// Reset (rst_n low, asynchronous) empties the set and clears the overflow flag.
// s_tready is high only while a set is being loaded; a stall on m holds the current result.
module stable_descending_argsort #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sda_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] sample_value
    input  logic                            s_tlast,   // is_final
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sda_pkg::M_TDATA_W-1:0]   m_tdata,   // [3:0] rank_origin,
                                                       // [35:4] ranked_value, [39:36] zero
    output logic                            m_tlast,   // end_of_list
    output logic                            m_tuser    // overflowed
);

    // Index into the entry memory, and a fill counter that can also hold CAPACITY itself.
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = VALUE_BITS + sda_pkg::ORIGIN_W;

    // Each entry holds the value in its low bits and the arrival position above it.
    logic [ENTRY_W-1:0] entry_mem [CAPACITY];

    sda_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               overflow_reg, overflow_next;
    logic [IDX_W-1:0]   pass_end_reg, pass_end_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   last_idx_reg, last_idx_next;
    logic [ENTRY_W-1:0] carry_reg, carry_next;
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic                             fill_full;
    logic [CNT_W-1:0]                 count_m1;
    logic [63:0]                      in_ext;
    logic [CNT_W+sda_pkg::ORIGIN_W-1:0] fill_ext;
    logic [ENTRY_W-1:0]               in_entry;
    logic [VALUE_BITS-1:0]            carry_val;
    logic [VALUE_BITS-1:0]            rd_val;
    logic [VALUE_BITS+31:0]           out_ext;
    logic                             cmp_less;
    logic                             out_last;

    // Incoming sample: sign-extend, then keep VALUE_BITS bits. The arrival position is the
    // fill count before the write, of which only the low bits travel with the entry.
    assign in_ext    = {{32{s_tdata[31]}}, s_tdata};
    assign fill_ext  = {{sda_pkg::ORIGIN_W{1'b0}}, fill_reg};
    assign in_entry  = {fill_ext[sda_pkg::ORIGIN_W-1:0], in_ext[VALUE_BITS-1:0]};
    assign fill_full = (fill_reg == CNT_W'(CAPACITY));

    // Index of the last entry once the closing sample has been taken in.
    assign count_m1  = fill_full ? (fill_reg - CNT_W'(1)) : fill_reg;

    // The one shared comparator. A swap happens only on strictly less, which keeps equal
    // values in arrival order.
    assign carry_val = carry_reg[VALUE_BITS-1:0];
    assign rd_val    = rd_data_reg[VALUE_BITS-1:0];
    assign cmp_less  = $signed(carry_val) < $signed(rd_val);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sda_pkg::ST_LOAD;
            fill_reg     <= '0;
            overflow_reg <= 1'b0;
            pass_end_reg <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            last_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            overflow_reg <= overflow_next;
            pass_end_reg <= pass_end_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            last_idx_reg <= last_idx_next;
        end
    end

    // Entry memory with one write port and one registered read port, plus the carry
    // register that holds the entry being bubbled down the list.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[rd_addr];
        carry_reg   <= carry_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        overflow_next = overflow_reg;
        pass_end_next = pass_end_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        last_idx_next = last_idx_reg;
        carry_next    = carry_reg;
        rd_addr       = k_reg;
        wr_en         = 1'b0;
        wr_addr       = j_reg;
        wr_data       = carry_reg;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;

        case (state_reg)
            sda_pkg::ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (!fill_full)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = fill_reg[IDX_W-1:0];
                        wr_data   = in_entry;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        last_idx_next = count_m1[IDX_W-1:0];
                        pass_end_next = count_m1[IDX_W-1:0];
                        if (count_m1 == '0)
                        begin
                            state_next = sda_pkg::ST_OUT_PRIME;
                        end
                        else
                        begin
                            state_next = sda_pkg::ST_SORT_PRIME;
                        end
                    end
                end
            end

            sda_pkg::ST_SORT_PRIME:
            begin
                rd_addr    = '0;
                j_next     = IDX_W'(1);
                state_next = sda_pkg::ST_SORT_LOADC;
            end

            sda_pkg::ST_SORT_LOADC:
            begin
                // Entry 0 becomes the carry; fetch the first neighbor.
                carry_next = rd_data_reg;
                rd_addr    = j_reg;
                state_next = sda_pkg::ST_SORT_RUN;
            end

            sda_pkg::ST_SORT_RUN:
            begin
                // The slot behind the carry receives whichever entry ranks higher; the
                // other one moves on as the carry.
                wr_en   = 1'b1;
                wr_addr = j_reg - IDX_W'(1);
                if (cmp_less)
                begin
                    wr_data = rd_data_reg;
                end
                else
                begin
                    wr_data    = carry_reg;
                    carry_next = rd_data_reg;
                end
                if (j_reg == pass_end_reg)
                begin
                    state_next = sda_pkg::ST_SORT_TAIL;
                end
                else
                begin
                    j_next  = j_reg + IDX_W'(1);
                    rd_addr = j_reg + IDX_W'(1);
                end
            end

            sda_pkg::ST_SORT_TAIL:
            begin
                // The carry settles at the end of the pass. Entry 0 is fetched at the same
                // time, either for the next pass or as the first result.
                wr_en   = 1'b1;
                wr_addr = pass_end_reg;
                wr_data = carry_reg;
                rd_addr = '0;
                if (pass_end_reg == IDX_W'(1))
                begin
                    k_next     = '0;
                    state_next = sda_pkg::ST_OUT_SHOW;
                end
                else
                begin
                    pass_end_next = pass_end_reg - IDX_W'(1);
                    j_next        = IDX_W'(1);
                    state_next    = sda_pkg::ST_SORT_LOADC;
                end
            end

            sda_pkg::ST_OUT_PRIME:
            begin
                rd_addr    = '0;
                k_next     = '0;
                state_next = sda_pkg::ST_OUT_SHOW;
            end

            sda_pkg::ST_OUT_SHOW:
            begin
                // The read address runs one ahead on each accepted request, so a new
                // result is ready every cycle while m_tready stays high.
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (k_reg == last_idx_reg)
                    begin
                        fill_next     = '0;
                        overflow_next = 1'b0;
                        state_next    = sda_pkg::ST_LOAD;
                    end
                    else
                    begin
                        k_next  = k_reg + IDX_W'(1);
                        rd_addr = k_reg + IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = sda_pkg::ST_LOAD;
            end
        endcase
    end

    // Result fields: the low 32 bits of the stored value, sign-extended from VALUE_BITS.
    assign out_ext  = {{32{rd_val[VALUE_BITS-1]}}, rd_val};
    assign out_last = (k_reg == last_idx_reg);

    assign m_tdata = {{(sda_pkg::M_TDATA_W - sda_pkg::M_PAYLOAD_W){1'b0}},
                      out_ext[31:0],
                      rd_data_reg[ENTRY_W-1 -: sda_pkg::ORIGIN_W]};
    assign m_tlast = m_tvalid & out_last;
    assign m_tuser = overflow_reg;

endmodule

FILE: src/sda_checker.sv
module sda_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sda_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tlast,
    input logic                            m_tuser
);

    // The block either loads or emits, never both at once.
    a_phase_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("s_tready and m_tvalid are high together");

    // Closing a set stops the load side at once.
    a_close_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still ready after the closing request");

    // After the last result the block goes back to loading.
    a_end_returns_load: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("block did not return to loading after the last result");

    // A stalled result holds its payload.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind stable_descending_argsort sda_checker u_sda_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
